// ===== rtl/fol_pkg.sv =====
package fol_pkg;

	localparam int CAPACITY   = 16;
	localparam int COUNT_BITS = 16;
	localparam int VALUE_W    = 32;
	localparam int POS_W      = 4;
	localparam int ACC_W      = 16;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W      = $clog2(CAPACITY + 1);

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [OCC_W-1:0]      occ_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [VALUE_W-1:0]    value_t;

	typedef enum logic [1:0] {
		ST_APPENDED = 2'd0,
		ST_FULL     = 2'd1,
		ST_FOUND    = 2'd2,
		ST_MISS     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_MOVE = 1'b1
	} fsm_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic   en;
		logic   append;
		idx_t   hit;
		idx_t   dst;
		value_t new_value;
		count_t new_count;
	} cell_cmd_t;

endpackage

// ===== rtl/fol_cell.sv =====
module fol_cell
	import fol_pkg::*;
(
	input  logic      clk,
	input  idx_t      idx,
	input  cell_cmd_t cmd,
	input  value_t    cmp_value,
	input  value_t    left_value,
	input  count_t    left_count,
	input  value_t    right_value,
	input  count_t    right_count,
	output value_t    cell_value,
	output count_t    cell_count,
	output logic      match,
	output logic      le
);

	value_t value_q;
	count_t count_q;
	value_t value_d;
	count_t count_d;

	assign cell_value = value_q;
	assign cell_count = count_q;
	assign match      = (value_q == cmp_value);
	assign le         = (count_q <= cmd.new_count);

	always_comb begin
		value_d = value_q;
		count_d = count_q;
		if (cmd.en) begin
			if (cmd.append) begin
				if (idx == cmd.dst) begin
					value_d = cmd.new_value;
					count_d = '0;
				end
			end else if (idx == cmd.dst) begin
				value_d = cmd.new_value;
				count_d = cmd.new_count;
			end else if (cmd.dst <= cmd.hit && idx > cmd.dst && idx <= cmd.hit) begin
				// moving toward the head: open a slot by shifting down
				value_d = left_value;
				count_d = left_count;
			end else if (cmd.dst > cmd.hit && idx >= cmd.hit && idx < cmd.dst) begin
				// moving toward the tail: close the gap by shifting up
				value_d = right_value;
				count_d = right_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		count_q <= count_d;
	end

endmodule

// ===== rtl/frequency_ordered_list_top.sv =====
// Frequency-ordered list of up to CAPACITY signed 32-bit values with access counts.
// Input channel (in_valid/in_ready): kind 0 appends value at the tail, kind 1
// looks value up, bumps its count (saturating) and moves it ahead of every
// entry whose count is less than or equal to the new count.
// Output channel (out_valid/out_ready): one word per input word with status,
// position of the entry after the operation and its access count.
// The block takes one word at a time: in_ready is low from the accept until the
// result is registered. On accept the word is captured together with the
// parallel value compare across the cell row and the hit count increment; the
// move state then does the count compare and the one-step shift of the row.
// When the result register is still full, the block holds in its move state
// and in_ready stays low until the receiver takes the pending word.
// Reset clears the occupancy count and the control state; the cell contents
// are left as they are and never read before being written.
module frequency_ordered_list_top
	import fol_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    kind,
	input  logic signed [VALUE_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic [POS_W-1:0]        position,
	output logic [ACC_W-1:0]        access_count
);

	fsm_t state_q, state_d;
	occ_t occ_q;

	logic   kind_s1;
	value_t value_s1;
	logic   found_s1;
	idx_t   hit_s1;
	count_t cnt_s1;

	logic             out_valid_q;
	status_t          status_q;
	logic [POS_W-1:0] position_q;
	logic [ACC_W-1:0] acc_q;

	cell_cmd_t cmd;
	value_t    cell_value [CAPACITY];
	count_t    cell_count [CAPACITY];
	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] le;

	logic   accept;
	logic   out_free;
	logic   do_move;
	logic   hit_any;
	idx_t   hit_idx;
	count_t hit_cnt;
	count_t hit_cnt_inc;
	logic   le_any;
	idx_t   le_idx;
	idx_t   dst;
	occ_t   occ_m1;
	logic   full;

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		value_t lv, rv;
		count_t lc, rc;
		if (i == 0) begin : g_head
			assign lv = cell_value[i];
			assign lc = cell_count[i];
		end else begin : g_mid_l
			assign lv = cell_value[i-1];
			assign lc = cell_count[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign rv = cell_value[i];
			assign rc = cell_count[i];
		end else begin : g_mid_r
			assign rv = cell_value[i+1];
			assign rc = cell_count[i+1];
		end
		fol_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.cmd        (cmd),
			.cmp_value  (value_t'(value)),
			.left_value (lv),
			.left_count (lc),
			.right_value(rv),
			.right_count(rc),
			.cell_value (cell_value[i]),
			.cell_count (cell_count[i]),
			.match      (match[i]),
			.le         (le[i])
		);
	end

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign do_move  = (state_q == S_MOVE) && out_free;
	assign full     = (occ_q == OCC_W'(CAPACITY));
	assign occ_m1   = occ_q - OCC_W'(1);

	// first occupied cell holding the searched value
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i] && OCC_W'(i) < occ_q) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign hit_cnt     = cell_count[hit_idx];
	assign hit_cnt_inc = (hit_cnt == '1) ? hit_cnt : hit_cnt + COUNT_BITS'(1);

	// first other entry whose count does not exceed the new count
	always_comb begin
		le_any = 1'b0;
		le_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (le[i] && OCC_W'(i) < occ_q && IDX_W'(i) != hit_s1) begin
				le_any = 1'b1;
				le_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		if (!kind_s1)
			dst = occ_q[IDX_W-1:0];
		else if (!le_any)
			dst = occ_m1[IDX_W-1:0];
		else if (le_idx < hit_s1)
			dst = le_idx;
		else
			dst = le_idx - IDX_W'(1);
	end

	always_comb begin
		cmd.en        = do_move && (kind_s1 ? found_s1 : !full);
		cmd.append    = !kind_s1;
		cmd.hit       = hit_s1;
		cmd.dst       = dst;
		cmd.new_value = value_s1;
		cmd.new_count = cnt_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = S_MOVE;
			end
			S_MOVE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// capture the word together with the compare outcome
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			value_s1 <= value_t'(value);
			found_s1 <= hit_any;
			hit_s1   <= hit_idx;
			cnt_s1   <= hit_cnt_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_move)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (do_move && !kind_s1 && !full)
				occ_q <= occ_q + OCC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_move) begin
			if (!kind_s1) begin
				status_q   <= full ? ST_FULL : ST_APPENDED;
				position_q <= full ? '0 : POS_W'(occ_q);
				acc_q      <= '0;
			end else if (found_s1) begin
				status_q   <= ST_FOUND;
				position_q <= POS_W'(dst);
				acc_q      <= ACC_W'(cnt_s1);
			end else begin
				status_q   <= ST_MISS;
				position_q <= '0;
				acc_q      <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign position     = position_q;
	assign access_count = acc_q;

endmodule

// ===== rtl/fol_checker.sv =====
module fol_checker
	import fol_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      kind,
	input logic signed [VALUE_W-1:0] value,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [1:0]                status,
	input logic [POS_W-1:0]          position,
	input logic [ACC_W-1:0]          access_count
);

	// a stalled result word must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
			&& $stable(access_count))
		else $error("result word changed while stalled");

	// one word in flight: no accept right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	// no entry means zero position and count
	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_MISS)
			|-> position == '0 && access_count == '0)
		else $error("empty result carries position or count");

	// a fresh entry starts at count zero
	a_append_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_APPENDED |-> access_count == '0)
		else $error("appended entry has nonzero count");

endmodule

bind frequency_ordered_list_top fol_checker u_fol_checker (.*);

// ===== verif/frequency_ordered_list_checker.sv =====
`timescale 1ns / 100ps

package fol_test_pkg;
	import fol_pkg::*;

	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] position;
		logic [ACC_W-1:0] access_count;
	} list_result_t;
endpackage

module frequency_ordered_list_checker
	import fol_pkg::*;
	import fol_test_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      kind,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [1:0]                status,
	input  logic [POS_W-1:0]          position,
	input  logic [ACC_W-1:0]          access_count,
	output int                        mismatches,
	output int                        results_owed,
	output int                        appends_seen,
	output int                        fulls_seen,
	output int                        hits_seen,
	output int                        misses_seen
);

	value_t       list_value [CAPACITY];
	count_t       list_count [CAPACITY];
	int           list_len = 0;
	list_result_t awaited_results [$];

	int mismatch_total = 0;
	int owed = 0;
	int results_checked = 0;
	int n_append = 0;
	int n_full = 0;
	int n_hit = 0;
	int n_miss = 0;

	assign mismatches   = mismatch_total;
	assign results_owed = owed;
	assign appends_seen = n_append;
	assign fulls_seen   = n_full;
	assign hits_seen    = n_hit;
	assign misses_seen  = n_miss;

	// apply one word to the local copy of the list and return what it must report
	function automatic list_result_t access_list(logic k, value_t v);
		list_result_t r;
		int           hit;
		int           dst;
		int           i;
		count_t       cnt;
		bit           placed;
		r.status       = ST_MISS;
		r.position     = '0;
		r.access_count = '0;
		if (k == KIND_APPEND) begin
			if (list_len >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				list_value[list_len] = v;
				list_count[list_len] = '0;
				r.status   = ST_APPENDED;
				r.position = list_len[POS_W-1:0];
				list_len++;
			end
			return r;
		end
		// scan from the tail so the entry nearest the head wins
		hit = list_len;
		for (i = list_len - 1; i >= 0; i--)
			if (list_value[i] == v)
				hit = i;
		if (hit == list_len)
			return r;
		cnt = list_count[hit];
		if (cnt != '1)
			cnt++;
		// close the gap left by the hit entry
		for (i = hit; i + 1 < list_len; i++) begin
			list_value[i] = list_value[i + 1];
			list_count[i] = list_count[i + 1];
		end
		// go ahead of the first entry not above the new count, else to the tail
		dst    = list_len - 1;
		placed = 1'b0;
		for (i = 0; i + 1 < list_len; i++) begin
			if (!placed && list_count[i] <= cnt) begin
				dst    = i;
				placed = 1'b1;
			end
		end
		for (i = list_len - 1; i > dst; i--) begin
			list_value[i] = list_value[i - 1];
			list_count[i] = list_count[i - 1];
		end
		list_value[dst] = v;
		list_count[dst] = cnt;
		r.status       = ST_FOUND;
		r.position     = dst[POS_W-1:0];
		r.access_count = cnt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			list_len = 0;
			awaited_results.delete();
			owed <= 0;
		end else begin
			if (in_valid && in_ready)
				awaited_results.push_back(access_list(kind, value));
			if (out_valid && out_ready) begin
				results_checked++;
				if (awaited_results.size() == 0) begin
					if (mismatch_total < 10)
						$display("%0t: result %0d arrived with none awaited: status %0d position %0d count %0d",
							$time, results_checked, status, position, access_count);
					mismatch_total++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status || position !== want.position ||
							access_count !== want.access_count) begin
						if (mismatch_total < 10)
							$display({"%0t: result %0d mismatch (expected/actual): status %0d/%0d ",
								"position %0d/%0d count %0d/%0d"}, $time, results_checked,
								want.status, status, want.position, position,
								want.access_count, access_count);
						mismatch_total++;
					end
					case (want.status)
						ST_APPENDED: n_append++;
						ST_FULL:     n_full++;
						ST_FOUND:    n_hit++;
						default:     n_miss++;
					endcase
				end
			end
			owed <= awaited_results.size();
		end
	end

endmodule

// ===== verif/frequency_ordered_list_top_test.sv =====
`timescale 1ns / 100ps

module frequency_ordered_list_top_test;
	import fol_pkg::*;
	import fol_test_pkg::*;

	localparam int     RANDOM_WORDS   = 1025;
	localparam value_t MOST_NEGATIVE  = 32'h8000_0000;
	localparam value_t MOST_POSITIVE  = 32'h7FFF_FFFF;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      kind = KIND_APPEND;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [1:0]                status;
	logic [POS_W-1:0]          position;
	logic [ACC_W-1:0]          access_count;

	int mismatches;
	int results_owed;
	int appends_seen;
	int fulls_seen;
	int hits_seen;
	int misses_seen;

	bit     quiet = 1'b0;
	int     stall_left = 0;
	value_t members [$];

	always #5 clk = ~clk;

	frequency_ordered_list_top DUT (.*);

	frequency_ordered_list_checker list_check (.*);

	// receiver: mostly short stalls, now and then a long one
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 99) < 30) begin
			out_ready  <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ?
				$urandom_range(9, 29) : $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_word(input logic k, input value_t v);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		// nothing is ever removed, so the first CAPACITY appends are the members
		if (k == KIND_APPEND && members.size() < CAPACITY)
			members.push_back(v);
	endtask

	initial begin
		int     i;
		int     r;
		int     waited;
		value_t v;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(KIND_LOOKUP, '0);               // empty list
		send_word(KIND_APPEND, MOST_NEGATIVE);
		send_word(KIND_APPEND, MOST_POSITIVE);
		send_word(KIND_LOOKUP, MOST_NEGATIVE);
		send_word(KIND_LOOKUP, MOST_NEGATIVE);
		send_word(KIND_LOOKUP, MOST_POSITIVE);    // every other count is higher: stays at tail
		send_word(KIND_APPEND, '0);
		send_word(KIND_APPEND, '1);
		send_word(KIND_APPEND, '0);               // duplicate value
		send_word(KIND_LOOKUP, '0);               // first copy wins, passes an equal count
		send_word(KIND_LOOKUP, '1);
		send_word(KIND_LOOKUP, 32'h5A5A_5A5A);    // miss on a partly filled list
		for (i = 0; i < 11; i++) begin
			v = $urandom;
			send_word(KIND_APPEND, v);
		end
		send_word(KIND_APPEND, 32'h0000_0001);    // list full: drop
		send_word(KIND_LOOKUP, v);                // tail entry jumps forward

		for (i = 0; i < RANDOM_WORDS; i++) begin
			quiet <= ((i % 200) >= 150);
			r = $urandom_range(0, 99);
			if (r < 20) begin
				v = $urandom;
				send_word(KIND_APPEND, v);
			end else if (r < 30) begin
				v = $urandom;
				send_word(KIND_LOOKUP, v);
			end else begin
				send_word(KIND_LOOKUP, members[$urandom_range(0, members.size() - 1)]);
			end
		end
		in_valid <= 1'b0;
		quiet    <= 1'b1;

		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (results_owed != 0 && waited < 5000);
		repeat (6) @(posedge clk);

		if (results_owed != 0)
			$display("%0d results never arrived", results_owed);
		$display("words: %0d appended, %0d dropped on a full list, %0d hits, %0d misses",
			appends_seen, fulls_seen, hits_seen, misses_seen);
		$display("%0d words under random gaps and receiver stalls; %0d mismatches",
			appends_seen + fulls_seen + hits_seen + misses_seen, mismatches);
		if (mismatches == 0 && results_owed == 0)
			$display("frequency_ordered_list_top_test: PASS");
		else
			$display("frequency_ordered_list_top_test: FAIL");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("frequency_ordered_list_top_test: FAIL");
		$finish;
	end

endmodule

// ===== frequency_ordered_list_top.f =====
rtl/fol_pkg.sv
rtl/fol_cell.sv
rtl/frequency_ordered_list_top.sv
rtl/fol_checker.sv
verif/frequency_ordered_list_checker.sv
verif/frequency_ordered_list_top_test.sv
